// File: hw/rtl/geo_point_in_polygon_defines.svh
// Assertion macros for the point-in-polygon block.
// Used by the top level only; no other dependencies.
`ifndef GEO_POINT_IN_POLYGON_DEFINES_SVH
`define GEO_POINT_IN_POLYGON_DEFINES_SVH

`ifndef SYNTHESIS
`define GEO_PIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("geo_pip assertion failed");
`define GEO_PIP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("geo_pip assertion failed");
`else
`define GEO_PIP_ASSERT_NOW(lbl, ante, cons)
`define GEO_PIP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/geo_pip_pkg.sv
// Shared types, constants and a helper function of the point-in-polygon block.
// No dependencies.
package geo_pip_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int FRACTION_BITS = 16;
  localparam int MIN_SIDES     = 3;

  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = LON_W + 2;
  localparam int DLAT_W = LAT_W + 1;
  localparam int PROD_W = DIFF_W + DLAT_W;

  localparam logic signed [DIFF_W-1:0] DEG180 = DIFF_W'(180 * (2 ** FRACTION_BITS));
  localparam logic signed [DIFF_W-1:0] DEG360 = DIFF_W'(360 * (2 ** FRACTION_BITS));

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } vtx_t;

  typedef struct packed {
    logic             wr;
    logic             clr;
    logic             cap_pt;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             edge_rd;
    logic             cap_first;
    logic             cap_sides;
    logic             cap_prev;
    logic             odd_clr;
    logic             res_ld;
    status_t          res_status;
    logic             res_use_odd;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] sides;
    logic             full;
    logic             busy;
  } sts_t;

  function automatic logic signed [DIFF_W-1:0] wrap_diff(
    input logic signed [LON_W-1:0] a,
    input logic signed [LON_W-1:0] b
  );
    logic signed [DIFF_W-1:0] s;
    s = DIFF_W'(a) - DIFF_W'(b);
    if (s < -DEG180) begin
      s = s + DEG360;
    end else if (s > DEG180) begin
      s = s - DEG360;
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/geo_pip_ctrl.sv
// Controller state machine of the point-in-polygon block.
// Depends on geo_pip_pkg; drives the datapath through cmd_t and reads sts_t.
module geo_pip_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_opcode,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  geo_pip_pkg::sts_t   sts,
  output geo_pip_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD0  = 8'b0000_0010,
    S_RDL  = 8'b0000_0100,
    S_SID  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_PRV  = 8'b0010_0000,
    S_WALK = 8'b0100_0000,
    S_DRN  = 8'b1000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          out_vld_r, out_vld_nxt;
  logic [geo_pip_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [geo_pip_pkg::CNT_W-1:0] last_idx;
  logic [geo_pip_pkg::CNT_W-1:0] prev_idx;
  logic                          accept;

  assign in_ready  = (state_r == S_IDLE) && (!out_vld_r || out_ready);
  assign out_valid = out_vld_r;
  assign accept    = in_valid && in_ready;
  assign last_idx  = sts.total - geo_pip_pkg::CNT_W'(1);
  assign prev_idx  = sts.sides - geo_pip_pkg::CNT_W'(1);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.res_status = geo_pip_pkg::ST_OK;
          unique case (geo_pip_pkg::opcode_t'(in_opcode))
            geo_pip_pkg::OP_CLEAR: begin
              cmd.clr    = 1'b1;
              cmd.res_ld = 1'b1;
            end
            geo_pip_pkg::OP_ADD: begin
              cmd.wr     = 1'b1;
              cmd.res_ld = 1'b1;
              if (sts.full) begin
                cmd.res_status = geo_pip_pkg::ST_FULL;
              end
            end
            geo_pip_pkg::OP_QUERY: begin
              cmd.cap_pt = 1'b1;
              state_nxt  = S_RD0;
            end
            default: begin
              cmd.res_ld = 1'b1;
            end
          endcase
        end
      end
      S_RD0: begin
        if (sts.total < geo_pip_pkg::CNT_W'(geo_pip_pkg::MIN_SIDES)) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = geo_pip_pkg::ST_FEW;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = '0;
          state_nxt   = S_RDL;
        end
      end
      S_RDL: begin
        cmd.cap_first = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_addr   = last_idx[geo_pip_pkg::IDX_W-1:0];
        state_nxt     = S_SID;
      end
      S_SID: begin
        cmd.cap_sides = 1'b1;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        if (sts.sides < geo_pip_pkg::CNT_W'(geo_pip_pkg::MIN_SIDES)) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = geo_pip_pkg::ST_FEW;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = prev_idx[geo_pip_pkg::IDX_W-1:0];
          state_nxt   = S_PRV;
        end
      end
      S_PRV: begin
        cmd.cap_prev = 1'b1;
        cmd.odd_clr  = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.edge_rd  = 1'b1;
        cmd.rd_addr  = '0;
        cnt_nxt      = geo_pip_pkg::CNT_W'(1);
        state_nxt    = S_WALK;
      end
      S_WALK: begin
        if (cnt_r < sts.sides) begin
          cmd.rd_en   = 1'b1;
          cmd.edge_rd = 1'b1;
          cmd.rd_addr = cnt_r[geo_pip_pkg::IDX_W-1:0];
          cnt_nxt     = cnt_r + geo_pip_pkg::CNT_W'(1);
        end else begin
          state_nxt = S_DRN;
        end
      end
      S_DRN: begin
        if (!sts.busy) begin
          cmd.res_ld      = 1'b1;
          cmd.res_use_odd = 1'b1;
          cmd.res_status  = geo_pip_pkg::ST_OK;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.res_ld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/geo_pip_dp.sv
// Datapath of the point-in-polygon block: vertex memory, edge pipeline, result register.
// Depends on geo_pip_pkg; controlled by geo_pip_ctrl through cmd_t.
module geo_pip_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [geo_pip_pkg::LAT_W-1:0]  in_lat,
  input  logic signed [geo_pip_pkg::LON_W-1:0]  in_lon,
  input  geo_pip_pkg::cmd_t                     cmd,
  output geo_pip_pkg::sts_t                     sts,
  output logic                                  out_inside_res,
  output logic [1:0]                            out_status
);

  geo_pip_pkg::vtx_t mem [geo_pip_pkg::MAX_VERTICES];

  logic [geo_pip_pkg::CNT_W-1:0] total_r, total_nxt;
  logic [geo_pip_pkg::CNT_W-1:0] sides_r;
  logic                          full;
  geo_pip_pkg::vtx_t             rd_data_r;
  geo_pip_pkg::vtx_t             first_r;
  geo_pip_pkg::vtx_t             prev_r;
  geo_pip_pkg::vtx_t             pt_r;

  logic                                  e0_vld_r, s1_vld_r, s2_vld_r;
  logic                                  br_nxt;
  logic                                  s1_br_r, s1_den_pos_r;
  logic signed [geo_pip_pkg::DIFF_W-1:0] s1_dlon_r, s1_dseg_r;
  logic signed [geo_pip_pkg::DLAT_W-1:0] s1_dlat_r, s1_den_r;
  logic signed [geo_pip_pkg::DLAT_W-1:0] dlat_nxt, den_nxt;
  logic                                  s2_br_r, s2_den_pos_r;
  logic signed [geo_pip_pkg::PROD_W-1:0] s2_num_r, s2_rhs_r;
  logic signed [geo_pip_pkg::PROD_W-1:0] num_nxt, rhs_nxt;
  logic                                  left;
  logic                                  odd_r;

  assign full      = (total_r == geo_pip_pkg::CNT_W'(geo_pip_pkg::MAX_VERTICES));
  assign sts.total = total_r;
  assign sts.sides = sides_r;
  assign sts.full  = full;
  assign sts.busy  = e0_vld_r || s1_vld_r || s2_vld_r;

  always_comb begin
    priority if (cmd.clr) begin
      total_nxt = '0;
    end else if (cmd.wr && !full) begin
      total_nxt = total_r + geo_pip_pkg::CNT_W'(1);
    end else begin
      total_nxt = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && !full) begin
      mem[total_r[geo_pip_pkg::IDX_W-1:0]] <= '{lat: in_lat, lon: in_lon};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // Edge from vertex j (prev_r) to vertex i (rd_data_r), against point pt_r.
  always_comb begin
    br_nxt = ((prev_r.lat < pt_r.lat) && (rd_data_r.lat >= pt_r.lat)) ||
             ((rd_data_r.lat < pt_r.lat) && (prev_r.lat >= pt_r.lat));
    dlat_nxt = geo_pip_pkg::DLAT_W'(pt_r.lat) - geo_pip_pkg::DLAT_W'(rd_data_r.lat);
    den_nxt  = geo_pip_pkg::DLAT_W'(prev_r.lat) - geo_pip_pkg::DLAT_W'(rd_data_r.lat);
    num_nxt  = geo_pip_pkg::PROD_W'(s1_dlat_r) * geo_pip_pkg::PROD_W'(s1_dseg_r);
    rhs_nxt  = geo_pip_pkg::PROD_W'(s1_dlon_r) * geo_pip_pkg::PROD_W'(s1_den_r);
    left     = s2_den_pos_r ? (s2_num_r < s2_rhs_r) : (s2_num_r > s2_rhs_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_pt) begin
      pt_r <= '{lat: in_lat, lon: in_lon};
    end
    if (cmd.cap_first) begin
      first_r <= rd_data_r;
    end
    if (cmd.cap_sides) begin
      sides_r <= total_r - geo_pip_pkg::CNT_W'(rd_data_r == first_r);
    end
    if (cmd.cap_prev || e0_vld_r) begin
      prev_r <= rd_data_r;
    end
    s1_br_r      <= br_nxt;
    s1_dlat_r    <= dlat_nxt;
    s1_den_r     <= den_nxt;
    s1_den_pos_r <= den_nxt > 0;
    s1_dlon_r    <= geo_pip_pkg::wrap_diff(pt_r.lon, rd_data_r.lon);
    s1_dseg_r    <= geo_pip_pkg::wrap_diff(prev_r.lon, rd_data_r.lon);
    s2_br_r      <= s1_br_r;
    s2_den_pos_r <= s1_den_pos_r;
    s2_num_r     <= num_nxt;
    s2_rhs_r     <= rhs_nxt;
    if (cmd.odd_clr) begin
      odd_r <= 1'b0;
    end else if (s2_vld_r && s2_br_r && left) begin
      odd_r <= !odd_r;
    end
    if (cmd.res_ld) begin
      out_inside_res <= cmd.res_use_odd && odd_r;
      out_status     <= cmd.res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      e0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      total_r  <= total_nxt;
      e0_vld_r <= cmd.edge_rd;
      s1_vld_r <= e0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

endmodule

// File: hw/rtl/geo_point_in_polygon.sv
// Top level of the point-in-polygon tester: controller plus datapath.
// Depends on geo_pip_pkg, geo_pip_ctrl, geo_pip_dp and the assertion macro header.
//
//   port group   direction   beat contents
//   in_*         input       opcode, lat, lon
//   out_*        output      inside_res, status
//
// Clear, add and unused opcodes are answered from idle; the result beat is registered.
// A query over three or more sides runs setup states S_RD0, S_RDL, S_SID, S_CHK and S_PRV
// that read the first and last vertices, then one vertex memory read per edge follows,
// and the three-stage edge pipeline with one multiply pair per edge drains in S_DRN.
// With fewer than three stored vertices a query ends in S_RD0 with status ST_FEW.
// Reset empties the vertex table; stored vertices are not cleared.
// A stalled result beat holds the next input until it is taken.
`include "geo_point_in_polygon_defines.svh"

module geo_point_in_polygon (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_opcode,
  input  logic signed [geo_pip_pkg::LAT_W-1:0] in_lat,
  input  logic signed [geo_pip_pkg::LON_W-1:0] in_lon,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_inside_res,
  output logic [1:0]                           out_status
);

  geo_pip_pkg::cmd_t cmd;
  geo_pip_pkg::sts_t sts;
  logic              add_beat;

  assign add_beat = in_valid && in_ready && (in_opcode == geo_pip_pkg::OP_ADD) && !sts.full;

  geo_pip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  geo_pip_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_lat         (in_lat),
    .in_lon         (in_lon),
    .cmd            (cmd),
    .sts            (sts),
    .out_inside_res (out_inside_res),
    .out_status     (out_status)
  );

  `GEO_PIP_ASSERT_NOW(a_idle_pipe_empty, in_ready, !sts.busy)
  `GEO_PIP_ASSERT_NXT(a_add_counts, add_beat, sts.total == $past(sts.total) + geo_pip_pkg::CNT_W'(1))
  `GEO_PIP_ASSERT_NOW(a_edge_in_range, cmd.edge_rd, geo_pip_pkg::CNT_W'(cmd.rd_addr) < sts.sides)
  `GEO_PIP_ASSERT_NOW(a_total_bound, cmd.res_ld, sts.total <= geo_pip_pkg::CNT_W'(64))

endmodule
